FILE: sv/dcfb_pkg.sv
// Shared types, codes and constants of the DCF contention backoff engine.
`timescale 1ns / 1ps
`default_nettype none

package dcfb_pkg;

    // Default parameter values
    localparam int TIME_BITS_DEF = 48;
    localparam int CW_BITS_DEF   = 10;

    // Fixed field widths
    localparam int KIND_W     = 3;
    localparam int RETRY_W    = 4;
    localparam int RND_W      = 16;
    localparam int IFS_W      = 20;
    localparam int CWREG_W    = 10;
    localparam int SLOT_W     = 16;
    localparam int ST_W       = 2;
    localparam int BO_W       = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IFS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EIFS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT   = 3'd4;

    // Configuration reset values
    localparam logic [IFS_W-1:0]   IFS_RST    = 20'd34000;
    localparam logic [IFS_W-1:0]   EIFS_RST   = 20'd94000;
    localparam logic [CWREG_W-1:0] CW_MIN_RST = 10'd15;
    localparam logic [CWREG_W-1:0] CW_MAX_RST = 10'd1023;
    localparam logic [SLOT_W-1:0]  SLOT_RST   = 16'd9000;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MEDIUM  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CORRUPT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COLL    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TXFIN   = 3'd5;

    // Contention states
    localparam logic [ST_W-1:0] ST_IDLE    = 2'd0;
    localparam logic [ST_W-1:0] ST_DEFER   = 2'd1;
    localparam logic [ST_W-1:0] ST_BACKOFF = 2'd2;
    localparam logic [ST_W-1:0] ST_TX      = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic rec_medium;
        logic set_eifs;
        logic div_draw;
        logic div_frz;
        logic div_step;
        logic take_draw;
        logic frz_zero;
        logic frz_take;
        logic plan_a;
        logic plan_b;
        logic plan_c;
        logic plan_d;
        logic out_load;
        logic out_sched;
    } dcfb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic medium_free;
        logic sched_le_now;
        logic slot_zero;
        logic div_done;
    } dcfb_sts_t;

    // Result flags of one event
    typedef struct packed {
        logic sched;
        logic cancel;
        logic send;
        logic done;
        logic coll;
        logic err;
    } dcfb_flags_t;

endpackage

`default_nettype wire

FILE: sv/dcfb_evt_if.sv
// Event channel: valid/ready handshake with the event payload.
`timescale 1ns / 1ps
`default_nettype none

interface dcfb_evt_if #(
    parameter int TIME_BITS = dcfb_pkg::TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [dcfb_pkg::KIND_W-1:0]  kind;
    logic [TIME_BITS-1:0]         now;
    logic                         medium_free;
    logic [dcfb_pkg::RETRY_W-1:0] retry_count;
    logic [dcfb_pkg::RND_W-1:0]   random_word;

    modport source (
        output valid, kind, now, medium_free, retry_count, random_word,
        input  ready
    );
    modport sink (
        input  valid, kind, now, medium_free, retry_count, random_word,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/dcfb_res_if.sv
// Result channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
`default_nettype none

interface dcfb_res_if #(
    parameter int TIME_BITS = dcfb_pkg::TIME_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic [dcfb_pkg::ST_W-1:0] state_after;
    logic                      schedule_request;
    logic [TIME_BITS-1:0]      request_time;
    logic                      cancel_request;
    logic                      send_frame;
    logic                      report_complete;
    logic                      report_collision;
    logic                      event_error;
    logic [dcfb_pkg::BO_W-1:0] backoff_left;

    modport source (
        output valid, state_after, schedule_request, request_time, cancel_request,
               send_frame, report_complete, report_collision, event_error,
               backoff_left,
        input  ready
    );
    modport sink (
        input  valid, state_after, schedule_request, request_time, cancel_request,
               send_frame, report_complete, report_collision, event_error,
               backoff_left,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/dcfb_dpath.sv
// Datapath: config registers, engine timing state, shared divider and planner.
`timescale 1ns / 1ps
`default_nettype none

module dcfb_dpath #(
    parameter int TIME_BITS = dcfb_pkg::TIME_BITS_DEF,
    parameter int CW_BITS   = dcfb_pkg::CW_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcfb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [TIME_BITS-1:0]            now,
    input  wire logic                            medium_free,
    input  wire logic [dcfb_pkg::RETRY_W-1:0]    retry_count,
    input  wire logic [dcfb_pkg::RND_W-1:0]      random_word,
    input  wire dcfb_pkg::dcfb_cmd_t             cmd,
    output dcfb_pkg::dcfb_sts_t                  sts,
    output logic [TIME_BITS-1:0]                 request_time,
    output logic [dcfb_pkg::BO_W-1:0]            backoff_left
);

    localparam int DIV_W  = (CW_BITS + 1 > dcfb_pkg::SLOT_W) ? CW_BITS + 1 : dcfb_pkg::SLOT_W;
    localparam int PROD_W = CW_BITS + dcfb_pkg::SLOT_W;
    localparam int WAIT_W = PROD_W + 1;
    localparam int CMP_W  = (TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W;
    localparam int SUM_W  = CMP_W + 1;
    localparam int SHL_W  = CW_BITS + (1 << dcfb_pkg::RETRY_W);
    localparam int CNT_W  = $clog2(TIME_BITS + 1);

    // Configuration registers
    logic [dcfb_pkg::IFS_W-1:0]   ifs_reg;
    logic [dcfb_pkg::IFS_W-1:0]   eifs_reg;
    logic [dcfb_pkg::CWREG_W-1:0] cwmin_reg;
    logic [dcfb_pkg::CWREG_W-1:0] cwmax_reg;
    logic [dcfb_pkg::SLOT_W-1:0]  slot_reg;

    // Engine timing state
    logic                         medium_reg;
    logic [TIME_BITS-1:0]         last_reg;
    logic [TIME_BITS-1:0]         eifs_end_reg;
    logic [CW_BITS-1:0]           backoff_reg;
    logic [TIME_BITS-1:0]         sched_reg;
    logic [dcfb_pkg::RETRY_W-1:0] held_retry_reg;

    // Latched event
    logic [TIME_BITS-1:0]         now_l;
    logic                         mfree_l;
    logic [dcfb_pkg::RETRY_W-1:0] retry_l;
    logic [dcfb_pkg::RND_W-1:0]   rnd_l;

    // Divider and planner
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [TIME_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 use_eifs_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [WAIT_W-1:0]    wait_reg;

    // Output payload
    logic [TIME_BITS-1:0]      req_time_reg;
    logic [dcfb_pkg::BO_W-1:0] bo_out_reg;

    logic [CW_BITS-1:0]   cw_lo;
    logic [CW_BITS-1:0]   cw_hi;
    logic [SHL_W-1:0]     win_shl;
    logic [SHL_W-1:0]     hi_p1;
    logic [DIV_W-1:0]     div_win;
    logic [DIV_W:0]       trial;
    logic                 trial_ge;
    logic [TIME_BITS:0]   frz_ceil;

    // Saturating time sum
    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [CMP_W-1:0]     b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if ((s >> TIME_BITS) != '0)
            sat_add = '1;
        else
            sat_add = s[TIME_BITS-1:0];
    endfunction

    // Contention window plus one: ((cw_min+1) << retry) capped at cw_max+1
    always_comb
    begin
        cw_lo   = CW_BITS'(cwmin_reg);
        cw_hi   = CW_BITS'(cwmax_reg);
        win_shl = (SHL_W'(cw_lo) + SHL_W'(1)) << retry_l;
        hi_p1   = SHL_W'(cw_hi) + SHL_W'(1);
        div_win = (win_shl > hi_p1) ? DIV_W'(hi_p1) : DIV_W'(win_shl);
    end

    // One restoring divide step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[TIME_BITS-1]};
        trial_ge = trial >= {1'b0, dvs_reg};
        frz_ceil = {1'b0, quo_reg} + (TIME_BITS + 1)'(rem_reg != '0);
    end

    // Configuration and engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ifs_reg        <= dcfb_pkg::IFS_RST;
            eifs_reg       <= dcfb_pkg::EIFS_RST;
            cwmin_reg      <= dcfb_pkg::CW_MIN_RST;
            cwmax_reg      <= dcfb_pkg::CW_MAX_RST;
            slot_reg       <= dcfb_pkg::SLOT_RST;
            medium_reg     <= 1'b1;
            last_reg       <= '0;
            eifs_end_reg   <= '0;
            backoff_reg    <= '0;
            sched_reg      <= '0;
            held_retry_reg <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dcfb_pkg::CFG_IFS:    ifs_reg   <= cfg_data;
                    dcfb_pkg::CFG_EIFS:   eifs_reg  <= cfg_data;
                    dcfb_pkg::CFG_CW_MIN: cwmin_reg <= cfg_data[dcfb_pkg::CWREG_W-1:0];
                    dcfb_pkg::CFG_CW_MAX: cwmax_reg <= cfg_data[dcfb_pkg::CWREG_W-1:0];
                    dcfb_pkg::CFG_SLOT:   slot_reg  <= cfg_data[dcfb_pkg::SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.rec_medium)
            begin
                medium_reg <= mfree_l;
                last_reg   <= now_l;
            end
            if (cmd.set_eifs)
                eifs_end_reg <= sat_add(now_l, CMP_W'(eifs_reg));
            if (cmd.div_draw || cmd.div_frz)
                cnt_reg <= CNT_W'(TIME_BITS);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - CNT_W'(1);
            // Backoff draw and freeze
            if (cmd.take_draw)
            begin
                backoff_reg    <= CW_BITS'(rem_reg);
                held_retry_reg <= retry_l;
            end
            else if (cmd.frz_zero)
                backoff_reg <= '0;
            else if (cmd.frz_take && (frz_ceil < (TIME_BITS + 1)'(backoff_reg)))
                backoff_reg <= CW_BITS'(frz_ceil);
            if (cmd.plan_d)
                sched_reg <= sat_add(now_l, CMP_W'(wait_reg));
        end
    end

    // Event latch, divider, planner and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_l   <= now;
            mfree_l <= medium_free;
            retry_l <= retry_count;
            rnd_l   <= random_word;
        end
        if (cmd.div_draw)
        begin
            dvs_reg <= div_win;
            quo_reg <= TIME_BITS'(rnd_l);
            rem_reg <= '0;
        end
        else if (cmd.div_frz)
        begin
            dvs_reg <= DIV_W'(slot_reg);
            quo_reg <= sched_reg - now_l;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[TIME_BITS-2:0], trial_ge};
        end
        // Plan: free time, IFS choice, slot product, remaining wait
        if (cmd.plan_a)
        begin
            prod_reg     <= PROD_W'(backoff_reg) * PROD_W'(slot_reg);
            use_eifs_reg <= eifs_end_reg > sat_add(now_l, CMP_W'(ifs_reg));
            elapsed_reg  <= (now_l >= last_reg) ? now_l - last_reg : '0;
        end
        if (cmd.plan_b)
            wait_reg <= WAIT_W'(use_eifs_reg ? eifs_reg : ifs_reg) + WAIT_W'(prod_reg);
        else if (cmd.plan_c && (held_retry_reg == '0))
            wait_reg <= (CMP_W'(elapsed_reg) > CMP_W'(wait_reg)) ? '0
                      : WAIT_W'(CMP_W'(wait_reg) - CMP_W'(elapsed_reg));
        if (cmd.out_load)
        begin
            req_time_reg <= cmd.out_sched ? sched_reg : '0;
            bo_out_reg   <= dcfb_pkg::BO_W'(backoff_reg);
        end
    end

    assign sts.medium_free  = medium_reg;
    assign sts.sched_le_now = sched_reg <= now_l;
    assign sts.slot_zero    = slot_reg == '0;
    assign sts.div_done     = cnt_reg == '0;

    assign request_time = req_time_reg;
    assign backoff_left = bo_out_reg;

endmodule

`default_nettype wire

FILE: sv/dcfb_ctrl.sv
// Controller: contention state machine and event sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dcfb_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          evt_valid,
    output logic                               evt_ready,
    input  wire logic [dcfb_pkg::KIND_W-1:0]   evt_kind,
    input  wire logic                          evt_medium_free,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [dcfb_pkg::ST_W-1:0]          res_state,
    output dcfb_pkg::dcfb_flags_t              res_flags,
    output dcfb_pkg::dcfb_cmd_t                cmd,
    input  wire dcfb_pkg::dcfb_sts_t           sts
);

    localparam logic [3:0] SQ_IDLE = 4'd0;
    localparam logic [3:0] SQ_DEC  = 4'd1;
    localparam logic [3:0] SQ_DIV  = 4'd2;
    localparam logic [3:0] SQ_DRAW = 4'd3;
    localparam logic [3:0] SQ_FRZ  = 4'd4;
    localparam logic [3:0] SQ_P1   = 4'd5;
    localparam logic [3:0] SQ_P2   = 4'd6;
    localparam logic [3:0] SQ_P3   = 4'd7;
    localparam logic [3:0] SQ_P4   = 4'd8;
    localparam logic [3:0] SQ_FIN  = 4'd9;

    logic [3:0]                  sq_reg, sq_next;
    logic [dcfb_pkg::ST_W-1:0]   fsm_reg, fsm_next;
    logic [dcfb_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic                        mfree_reg, mfree_next;
    logic                        plan_reg, plan_next;
    logic                        frz_reg, frz_next;
    dcfb_pkg::dcfb_flags_t       flg_reg, flg_next;
    logic                        out_valid_reg, out_valid_next;
    logic [dcfb_pkg::ST_W-1:0]   out_state_reg, out_state_next;
    dcfb_pkg::dcfb_flags_t       out_flg_reg, out_flg_next;

    // Sequencer and event decode
    always_comb
    begin
        sq_next        = sq_reg;
        fsm_next       = fsm_reg;
        kind_next      = kind_reg;
        mfree_next     = mfree_reg;
        plan_next      = plan_reg;
        frz_next       = frz_reg;
        flg_next       = flg_reg;
        out_state_next = out_state_reg;
        out_flg_next   = out_flg_reg;
        out_valid_next = out_valid_reg && !res_ready;
        cmd            = '0;

        case (sq_reg)
            SQ_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.load   = 1'b1;
                    kind_next  = evt_kind;
                    mfree_next = evt_medium_free;
                    flg_next   = '0;
                    sq_next    = SQ_DEC;
                end
            end
            SQ_DEC:
            begin
                sq_next = SQ_FIN;
                case (kind_reg)
                    dcfb_pkg::KIND_START:
                    begin
                        if (fsm_reg == dcfb_pkg::ST_IDLE)
                        begin
                            cmd.div_draw   = 1'b1;
                            frz_next       = 1'b0;
                            plan_next      = sts.medium_free;
                            flg_next.sched = sts.medium_free;
                            fsm_next       = sts.medium_free ? dcfb_pkg::ST_BACKOFF
                                                             : dcfb_pkg::ST_DEFER;
                            sq_next        = SQ_DIV;
                        end
                        else
                            flg_next.err = 1'b1;
                    end
                    dcfb_pkg::KIND_MEDIUM:
                    begin
                        cmd.rec_medium = 1'b1;
                        if (fsm_reg == dcfb_pkg::ST_DEFER)
                        begin
                            if (mfree_reg)
                            begin
                                fsm_next       = dcfb_pkg::ST_BACKOFF;
                                flg_next.sched = 1'b1;
                                sq_next        = SQ_P1;
                            end
                            else
                                flg_next.err = 1'b1;
                        end
                        else if (fsm_reg == dcfb_pkg::ST_BACKOFF)
                        begin
                            if (!mfree_reg)
                            begin
                                fsm_next        = dcfb_pkg::ST_DEFER;
                                flg_next.cancel = 1'b1;
                                if (sts.sched_le_now)
                                    cmd.frz_zero = 1'b1;
                                else if (!sts.slot_zero)
                                begin
                                    cmd.div_frz = 1'b1;
                                    frz_next    = 1'b1;
                                    sq_next     = SQ_DIV;
                                end
                            end
                            else
                                flg_next.err = 1'b1;
                        end
                    end
                    dcfb_pkg::KIND_CORRUPT:
                    begin
                        if (fsm_reg == dcfb_pkg::ST_DEFER)
                            cmd.set_eifs = 1'b1;
                        else if (fsm_reg == dcfb_pkg::ST_BACKOFF)
                        begin
                            cmd.set_eifs    = 1'b1;
                            flg_next.cancel = 1'b1;
                            flg_next.sched  = 1'b1;
                            sq_next         = SQ_P1;
                        end
                        else if (fsm_reg == dcfb_pkg::ST_TX)
                            flg_next.err = 1'b1;
                    end
                    dcfb_pkg::KIND_GRANT:
                    begin
                        if (fsm_reg == dcfb_pkg::ST_BACKOFF)
                        begin
                            fsm_next      = dcfb_pkg::ST_TX;
                            flg_next.send = 1'b1;
                        end
                        else
                            flg_next.err = 1'b1;
                    end
                    dcfb_pkg::KIND_COLL:
                    begin
                        if (fsm_reg == dcfb_pkg::ST_BACKOFF)
                        begin
                            fsm_next      = dcfb_pkg::ST_IDLE;
                            flg_next.coll = 1'b1;
                        end
                        else
                            flg_next.err = 1'b1;
                    end
                    dcfb_pkg::KIND_TXFIN:
                    begin
                        if (fsm_reg == dcfb_pkg::ST_TX)
                        begin
                            fsm_next      = dcfb_pkg::ST_IDLE;
                            flg_next.done = 1'b1;
                        end
                        else if (fsm_reg == dcfb_pkg::ST_BACKOFF)
                            flg_next.err = 1'b1;
                    end
                    default:
                        flg_next.err = 1'b1;
                endcase
            end
            SQ_DIV:
            begin
                if (sts.div_done)
                    sq_next = frz_reg ? SQ_FRZ : SQ_DRAW;
                else
                    cmd.div_step = 1'b1;
            end
            SQ_DRAW:
            begin
                cmd.take_draw = 1'b1;
                sq_next       = plan_reg ? SQ_P1 : SQ_FIN;
            end
            SQ_FRZ:
            begin
                cmd.frz_take = 1'b1;
                sq_next      = SQ_FIN;
            end
            SQ_P1:
            begin
                cmd.plan_a = 1'b1;
                sq_next    = SQ_P2;
            end
            SQ_P2:
            begin
                cmd.plan_b = 1'b1;
                sq_next    = SQ_P3;
            end
            SQ_P3:
            begin
                cmd.plan_c = 1'b1;
                sq_next    = SQ_P4;
            end
            SQ_P4:
            begin
                cmd.plan_d = 1'b1;
                sq_next    = SQ_FIN;
            end
            SQ_FIN:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || res_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sched  = flg_reg.sched;
                    out_valid_next = 1'b1;
                    out_state_next = fsm_reg;
                    out_flg_next   = flg_reg;
                    sq_next        = SQ_IDLE;
                end
            end
            default:
                sq_next = SQ_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg        <= SQ_IDLE;
            fsm_reg       <= dcfb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= '0;
            mfree_reg     <= 1'b0;
            plan_reg      <= 1'b0;
            frz_reg       <= 1'b0;
            flg_reg       <= '0;
            out_state_reg <= dcfb_pkg::ST_IDLE;
            out_flg_reg   <= '0;
        end
        else
        begin
            sq_reg        <= sq_next;
            fsm_reg       <= fsm_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            mfree_reg     <= mfree_next;
            plan_reg      <= plan_next;
            frz_reg       <= frz_next;
            flg_reg       <= flg_next;
            out_state_reg <= out_state_next;
            out_flg_reg   <= out_flg_next;
        end
    end

    assign evt_ready = sq_reg == SQ_IDLE;
    assign res_valid = out_valid_reg;
    assign res_state = out_state_reg;
    assign res_flags = out_flg_reg;

`ifndef SYNTHESIS
    // An accepted beat moves the sequencer straight to decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready) |=> (sq_reg == SQ_DEC))
        else $error("accepted beat did not enter decode");

    // An error result carries no other flag
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flg_reg.err) |->
        !(out_flg_reg.sched || out_flg_reg.cancel || out_flg_reg.send ||
          out_flg_reg.done || out_flg_reg.coll))
        else $error("error flag with other flags");

    // Frame send leaves the engine transmitting
    a_send_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flg_reg.send) |-> (out_state_reg == dcfb_pkg::ST_TX))
        else $error("send without transmit state");

    // Completion or collision returns the engine to idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_flg_reg.done || out_flg_reg.coll)) |->
        (out_state_reg == dcfb_pkg::ST_IDLE))
        else $error("completion or collision without idle state");
`endif

endmodule

`default_nettype wire

FILE: sv/wifi_dcf_contention_backoff.sv
// Top level of the DCF contention backoff engine.
`timescale 1ns / 1ps
`default_nettype none

// One event beat in, one result beat out. The block works on one event at a
// time: simple events (grant, collision, tx finished, ignored or refused
// events) go from decode straight to the result; a start, or a freeze on the
// medium turning busy before the scheduled time, runs the shared radix-2
// divider; a start with the medium free, the medium turning free in defer
// and a corrupt frame in backoff plan the grant time in four steps.
// The sequencer goes back to idle as the result is loaded, so the next event
// can be accepted in the following cycle.
// The result sits in an output register, so the next event is accepted while
// a result is still waiting. Configuration writes are applied at once and
// must only be made while the block is idle.
module wifi_dcf_contention_backoff #(
    parameter int TIME_BITS = dcfb_pkg::TIME_BITS_DEF,
    parameter int CW_BITS   = dcfb_pkg::CW_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcfb_pkg::CFG_DATA_W-1:0] cfg_data,
    dcfb_evt_if.sink                             evt,
    dcfb_res_if.source                           res
);

    dcfb_pkg::dcfb_cmd_t   cmd;
    dcfb_pkg::dcfb_sts_t   sts;
    dcfb_pkg::dcfb_flags_t flags;

    dcfb_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .evt_valid       (evt.valid),
        .evt_ready       (evt.ready),
        .evt_kind        (evt.kind),
        .evt_medium_free (evt.medium_free),
        .res_valid       (res.valid),
        .res_ready       (res.ready),
        .res_state       (res.state_after),
        .res_flags       (flags),
        .cmd             (cmd),
        .sts             (sts)
    );

    dcfb_dpath #(
        .TIME_BITS (TIME_BITS),
        .CW_BITS   (CW_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .now          (evt.now),
        .medium_free  (evt.medium_free),
        .retry_count  (evt.retry_count),
        .random_word  (evt.random_word),
        .cmd          (cmd),
        .sts          (sts),
        .request_time (res.request_time),
        .backoff_left (res.backoff_left)
    );

    // Result flags
    assign res.schedule_request = flags.sched;
    assign res.cancel_request   = flags.cancel;
    assign res.send_frame       = flags.send;
    assign res.report_complete  = flags.done;
    assign res.report_collision = flags.coll;
    assign res.event_error      = flags.err;

endmodule

`default_nettype wire
